[hdl/hsx_pkg.sv]
`default_nettype none

package hsx_pkg;

  // Conversion model codes carried in req_type.
  localparam logic [1:0] REQ_HSV  = 2'd0;
  localparam logic [1:0] REQ_HSL  = 2'd1;
  localparam logic [1:0] REQ_HSI  = 2'd2;
  localparam logic [1:0] REQ_RSVD = 2'd3;

  // Hue angles in 1/64 degree.
  localparam logic [14:0] DEG60  = 15'd3840;
  localparam logic [14:0] DEG120 = 15'd7680;
  localparam logic [14:0] DEG180 = 15'd11520;
  localparam logic [14:0] DEG240 = 15'd15360;
  localparam logic [14:0] DEG300 = 15'd19200;
  localparam logic [14:0] DEG360 = 15'd23040;

  // Channel scaling. HSV/HSL values are in units of 1/(510*3840), HSI values in
  // units of 1/(255*16384). The low power-of-two part of each divisor is a shift.
  localparam int unsigned HSV_ROUND = 32'd979200;
  localparam int unsigned HSI_ROUND = 32'd2088960;
  localparam int unsigned HSV_DIV   = 32'd7650;
  localparam int unsigned HSI_DIV   = 32'd255;
  localparam longint unsigned RECIP_ONE = 64'd4294967296;
  localparam int unsigned HSV_RECIP = 32'(RECIP_ONE / HSV_DIV);
  localparam int unsigned HSI_RECIP = 32'(RECIP_ONE / HSI_DIV);

  localparam int NUM_W   = 22;
  localparam int RECIP_W = 25;
  localparam int QUO_W   = 15;

  // Fixed-point constants for building the HSI ratio table.
  localparam longint Q28_ONE   = 64'sd268435456;
  localparam longint PI_Q28    = 64'sd843314857;
  localparam longint RATIO_ONE = 64'sd16384;
  localparam longint COS_DIV [14] = '{2, 12, 30, 56, 90, 132, 182, 240, 306, 380,
                                      462, 552, 650, 756};

  typedef struct packed {
    logic [1:0]  req_type;
    logic [14:0] hue;
    logic        hue_undefined;
    logic [7:0]  saturation;
    logic [7:0]  level;
    logic [7:0]  alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity;
  } color_t;

  // Per-pixel control that rides alongside the arithmetic.
  typedef struct packed {
    logic       valid;
    logic       use_hsi;
    logic       grey;
    logic [7:0] lvl;
    logic [7:0] alpha;
  } ctl_t;

  typedef struct packed {
    ctl_t        ctl;
    logic        undef;
    logic [2:0]  sec6;
    logic [11:0] t6;
    logic [16:0] c2;
    logic [16:0] m2;
    logic [1:0]  sec3;
    logic [12:0] h3;
    logic [7:0]  sat;
  } front_t;

  typedef struct packed {
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] g;
    logic [NUM_W-1:0] b;
  } rgb_num_t;

  // Taylor series cosine of a Q28 radian angle; elaboration use only.
  function automatic longint cos_q28(input longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) / Q28_ONE;
    term = Q28_ONE;
    sum  = Q28_ONE;
    for (int k = 0; k < 14; k++) begin
      term = -((term * x2) / Q28_ONE);
      term = term / COS_DIV[k];
      sum  = sum + term;
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

[hdl/hsx_front.sv]
`default_nettype none

module hsx_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            pixel_valid,
  input  hsx_pkg::pixel_t pixel,
  output hsx_pkg::front_t front
);

  logic [14:0] hue_r;
  logic [2:0]  sec6;
  logic [14:0] base6;
  logic [11:0] rem6;
  logic [11:0] t6;
  logic [1:0]  sec3;
  logic [14:0] base3;
  logic [7:0]  span;
  logic [7:0]  mul_b;
  logic [15:0] prod;
  logic [16:0] c2;
  logic [16:0] m2;
  logic        is_hsl;
  logic        grey;

  always_comb begin
    hue_r = (pixel.hue >= hsx_pkg::DEG360) ? pixel.hue - hsx_pkg::DEG360 : pixel.hue;
    sec6  = 3'(hue_r >= hsx_pkg::DEG60) + 3'(hue_r >= hsx_pkg::DEG120) +
            3'(hue_r >= hsx_pkg::DEG180) + 3'(hue_r >= hsx_pkg::DEG240) +
            3'(hue_r >= hsx_pkg::DEG300);
    base6 = 15'(sec6) * hsx_pkg::DEG60;
    rem6  = 12'(hue_r - base6);
    // Odd sectors run the intermediate component downward.
    t6    = sec6[0] ? 12'(hsx_pkg::DEG60) - rem6 : rem6;

    if (hue_r < hsx_pkg::DEG120) begin
      sec3  = 2'd0;
      base3 = '0;
    end else if (hue_r < hsx_pkg::DEG240) begin
      sec3  = 2'd1;
      base3 = hsx_pkg::DEG120;
    end else begin
      sec3  = 2'd2;
      base3 = hsx_pkg::DEG240;
    end

    // HSL span is 255 - |2L - 255|.
    span   = pixel.level[7] ? 8'(9'd510 - {pixel.level, 1'b0}) : {pixel.level[6:0], 1'b0};
    is_hsl = (pixel.req_type == hsx_pkg::REQ_HSL);
    mul_b  = is_hsl ? span : pixel.level;
    prod   = 16'(pixel.saturation) * 16'(mul_b);
    c2     = {prod, 1'b0};
    m2     = 17'(pixel.level) * 17'd510 - (is_hsl ? 17'(prod) : c2);

    grey = ((pixel.req_type == hsx_pkg::REQ_HSI) &&
            ((pixel.saturation == 8'd0) || pixel.hue_undefined)) ||
           (pixel.req_type == hsx_pkg::REQ_RSVD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.ctl.valid <= 1'b0;
    end else if (en) begin
      front.ctl.valid   <= pixel_valid;
      front.ctl.use_hsi <= (pixel.req_type == hsx_pkg::REQ_HSI);
      front.ctl.grey    <= grey;
      front.ctl.lvl     <= pixel.level;
      front.ctl.alpha   <= pixel.alpha;
      front.undef       <= pixel.hue_undefined;
      front.sec6        <= sec6;
      front.t6          <= t6;
      front.c2          <= c2;
      front.m2          <= m2;
      front.sec3        <= sec3;
      front.h3          <= 13'(hue_r - base3);
      front.sat         <= pixel.saturation;
    end
  end

endmodule

`default_nettype wire

[hdl/hsx_hsv.sv]
`default_nettype none

module hsx_hsv (
  input  logic              clk,
  input  logic              en,
  input  hsx_pkg::front_t   front,
  output hsx_pkg::rgb_num_t num
);

  logic [28:0] v1_x;
  logic [28:0] v1_c;
  logic [28:0] v1_m;
  logic [2:0]  v1_sec;
  logic        v1_undef;
  logic [28:0] ar;
  logic [28:0] ag;
  logic [28:0] ab;
  logic [29:0] v2_r;
  logic [29:0] v2_g;
  logic [29:0] v2_b;
  hsx_pkg::rgb_num_t v3;
  hsx_pkg::rgb_num_t dly [3];

  always_ff @(posedge clk) begin
    if (en) begin
      v1_x     <= 29'(front.c2) * 29'(front.t6);
      v1_c     <= 29'(front.c2) * 29'(hsx_pkg::DEG60);
      v1_m     <= 29'(front.m2) * 29'(hsx_pkg::DEG60);
      v1_sec   <= front.sec6;
      v1_undef <= front.undef;
    end
  end

  // Chroma and intermediate go onto the channels that the sector picks.
  always_comb begin
    ar = '0;
    ag = '0;
    ab = '0;
    if (!v1_undef) begin
      case (v1_sec)
        3'd0: begin ar = v1_c; ag = v1_x; end
        3'd1: begin ar = v1_x; ag = v1_c; end
        3'd2: begin ag = v1_c; ab = v1_x; end
        3'd3: begin ag = v1_x; ab = v1_c; end
        3'd4: begin ar = v1_x; ab = v1_c; end
        default: begin ar = v1_c; ab = v1_x; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r <= 30'(v1_m) + 30'(ar);
      v2_g <= 30'(v1_m) + 30'(ag);
      v2_b <= 30'(v1_m) + 30'(ab);
      v3.r <= 22'((32'(v2_r) + hsx_pkg::HSV_ROUND) >> 8);
      v3.g <= 22'((32'(v2_g) + hsx_pkg::HSV_ROUND) >> 8);
      v3.b <= 22'((32'(v2_b) + hsx_pkg::HSV_ROUND) >> 8);
      dly[0] <= v3;
      for (int i = 1; i < 3; i++) begin
        dly[i] <= dly[i-1];
      end
    end
  end

  assign num = dly[2];

endmodule

`default_nettype wire

[hdl/hsx_hsi.sv]
`default_nettype none

module hsx_hsi #(
  parameter int RATIO_TABLE_DEPTH = 128
) (
  input  logic              clk,
  input  logic              en,
  input  hsx_pkg::front_t   front,
  output hsx_pkg::rgb_num_t num
);

  localparam int AW = $clog2(7680 * RATIO_TABLE_DEPTH);
  localparam int VW = AW - 9;
  localparam int PW = VW + 13;
  localparam int QW = PW - 16;
  localparam int IW = $clog2(RATIO_TABLE_DEPTH);
  localparam logic [12:0] RECIP15 = 13'd4369;

  // Ratio cos(H)/cos(60deg - H) in signed Q14, one entry per step of the sector.
  logic signed [16:0] ratio_rom [RATIO_TABLE_DEPTH];

  for (genvar k = 0; k < RATIO_TABLE_DEPTH; k++) begin : g_rom
    localparam longint H   = (longint'(k) * 2 * hsx_pkg::PI_Q28) / (3 * RATIO_TABLE_DEPTH);
    localparam longint CN  = hsx_pkg::cos_q28(H);
    localparam longint CDR = hsx_pkg::cos_q28(hsx_pkg::PI_Q28 / 3 - H);
    localparam longint CD  = (CDR <= 0) ? longint'(1) : CDR;
    localparam longint NUM = CN * hsx_pkg::RATIO_ONE;
    localparam longint RAT = (NUM >= 0) ? (NUM + CD / 2) / CD : -((-NUM + CD / 2) / CD);
    localparam longint ENTRY = (k == 0) ? 2 * hsx_pkg::RATIO_ONE : RAT;
    assign ratio_rom[k] = 17'(ENTRY);
  end

  logic [AW-1:0]      h1_a;
  logic [7:0]         h1_sat, h2_sat, h3_sat, h4_sat;
  logic [7:0]         h1_lvl, h2_lvl, h3_lvl, h4_lvl;
  logic [1:0]         h1_sec, h2_sec, h3_sec, h4_sec, h5_sec;
  logic [VW-1:0]      vin;
  logic [PW-1:0]      qprod;
  logic [VW-1:0]      h2_v;
  logic [QW-1:0]      h2_q;
  logic [VW:0]        rem;
  logic [QW-1:0]      idx_full;
  logic [IW-1:0]      idx;
  logic signed [16:0] h3_ratio;
  logic signed [25:0] h4_sr;
  logic [15:0]        h4_ml;
  logic signed [26:0] inner_maj;
  logic signed [26:0] inner_mnr;
  logic signed [35:0] h5_maj;
  logic signed [35:0] h5_mnr;
  logic [29:0]        h5_mid;
  logic signed [35:0] maj_rnd;
  logic signed [35:0] mnr_rnd;
  logic [31:0]        mid_rnd;
  logic [hsx_pkg::NUM_W-1:0] s_maj, s_mnr, s_mid;

  always_comb begin
    vin   = h1_a[AW-1:9];
    qprod = PW'(vin) * PW'(RECIP15);
    // Quotient estimate by 15 is low by at most one.
    rem   = (VW+1)'(h2_v) - (VW+1)'(h2_q) * (VW+1)'(15);
    idx_full = (rem >= (VW+1)'(15)) ? h2_q + QW'(1) : h2_q;
    if (idx_full >= QW'(RATIO_TABLE_DEPTH)) begin
      idx = IW'(RATIO_TABLE_DEPTH - 1);
    end else begin
      idx = idx_full[IW-1:0];
    end
    inner_maj = 27'sd4177920 + h4_sr;
    inner_mnr = 27'sd4177920 + $signed({5'b0, h4_sat, 14'b0}) - h4_sr;
    maj_rnd   = h5_maj + 36'sd2088960;
    mnr_rnd   = h5_mnr + 36'sd2088960;
    mid_rnd   = 32'(h5_mid) + hsx_pkg::HSI_ROUND;
    s_maj     = (h5_maj > 36'sd0) ? maj_rnd[35:14] : '0;
    s_mnr     = (h5_mnr > 36'sd0) ? mnr_rnd[35:14] : '0;
    s_mid     = hsx_pkg::NUM_W'(mid_rnd[31:14]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_a     <= AW'(front.h3) * AW'(RATIO_TABLE_DEPTH);
      h1_sat   <= front.sat;
      h1_lvl   <= front.ctl.lvl;
      h1_sec   <= front.sec3;

      h2_v     <= vin;
      h2_q     <= qprod[PW-1:16];
      h2_sat   <= h1_sat;
      h2_lvl   <= h1_lvl;
      h2_sec   <= h1_sec;

      h3_ratio <= ratio_rom[idx];
      h3_sat   <= h2_sat;
      h3_lvl   <= h2_lvl;
      h3_sec   <= h2_sec;

      h4_sr    <= $signed({1'b0, h3_sat}) * h3_ratio;
      h4_ml    <= 16'(h3_lvl) * 16'(8'd255 - h3_sat);
      h4_sat   <= h3_sat;
      h4_lvl   <= h3_lvl;
      h4_sec   <= h3_sec;

      h5_maj   <= $signed({1'b0, h4_lvl}) * inner_maj;
      h5_mnr   <= $signed({1'b0, h4_lvl}) * inner_mnr;
      h5_mid   <= {h4_ml, 14'b0};
      h5_sec   <= h4_sec;

      case (h5_sec)
        2'd0: begin num.r <= s_maj; num.g <= s_mnr; num.b <= s_mid; end
        2'd1: begin num.r <= s_mid; num.g <= s_maj; num.b <= s_mnr; end
        default: begin num.r <= s_mnr; num.g <= s_mid; num.b <= s_maj; end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/hsx_div.sv]
`default_nettype none

module hsx_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [hsx_pkg::NUM_W-1:0] num,
  input  logic                      use_hsi,
  output logic [7:0]                chan
);

  localparam int PW = hsx_pkg::NUM_W + hsx_pkg::RECIP_W;

  logic [hsx_pkg::RECIP_W-1:0] recip;
  logic [PW-1:0]               d1_prod;
  logic [hsx_pkg::NUM_W-1:0]   d1_num;
  logic                        d1_hsi;
  logic [hsx_pkg::QUO_W-1:0]   q0;
  logic [27:0]                 qd;
  logic [27:0]                 divisor;
  logic [27:0]                 rem;
  logic [hsx_pkg::QUO_W:0]     q;

  assign recip = use_hsi ? hsx_pkg::RECIP_W'(hsx_pkg::HSI_RECIP)
                         : hsx_pkg::RECIP_W'(hsx_pkg::HSV_RECIP);

  // Reciprocal estimate is at most one short; one compare fixes it.
  always_comb begin
    q0      = d1_prod[PW-1:32];
    divisor = d1_hsi ? 28'(hsx_pkg::HSI_DIV) : 28'(hsx_pkg::HSV_DIV);
    qd      = 28'(q0) * divisor;
    rem     = 28'(d1_num) - qd;
    q       = (rem >= divisor) ? (hsx_pkg::QUO_W+1)'(q0) + 1'b1 : (hsx_pkg::QUO_W+1)'(q0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_prod <= PW'(num) * PW'(recip);
      d1_num  <= num;
      d1_hsi  <= use_hsi;
      chan    <= (q > (hsx_pkg::QUO_W+1)'(255)) ? 8'd255 : q[7:0];
    end
  end

endmodule

`default_nettype wire

[hdl/hsv_hsl_hsi_to_rgb.sv]
// Pipeline: 9 register stages lie between a pixel transfer and the offer of its color.
// Throughput: one pixel per clock; a stalled output freezes every stage together.
// Reset: synchronous, active-high rst clears all stage valid bits; no clearing pass.
// The HSI ratio table is constant logic, so the block is ready right after reset.
`default_nettype none

module hsv_hsl_hsi_to_rgb #(
  parameter int RATIO_TABLE_DEPTH = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            pixel_valid,
  output logic            pixel_ready,
  input  hsx_pkg::pixel_t pixel,
  output logic            color_valid,
  input  logic            color_ready,
  output hsx_pkg::color_t color
);

  localparam int CTL_DEPTH = 8;

  // Stage map: front (1), model arithmetic (2..7), divide (8, 9). The control
  // pipe carries valid, grey select, level and alpha beside the data stages.
  logic              en;
  hsx_pkg::front_t   front_q;
  hsx_pkg::ctl_t     ctl_q [CTL_DEPTH];
  hsx_pkg::rgb_num_t hsv_num;
  hsx_pkg::rgb_num_t hsi_num;
  hsx_pkg::rgb_num_t sel_num;
  logic [7:0]        red_q;
  logic [7:0]        green_q;
  logic [7:0]        blue_q;

  // The whole pipe advances whenever the output register is empty or is being
  // taken, so no new pixel transfer can happen while an older color waits.
  assign en          = !ctl_q[CTL_DEPTH-1].valid || color_ready;
  assign pixel_ready = en;

  hsx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .pixel_valid (pixel_valid),
    .pixel       (pixel),
    .front       (front_q)
  );

  hsx_hsv u_hsv (
    .clk   (clk),
    .en    (en),
    .front (front_q),
    .num   (hsv_num)
  );

  hsx_hsi #(
    .RATIO_TABLE_DEPTH (RATIO_TABLE_DEPTH)
  ) u_hsi (
    .clk   (clk),
    .en    (en),
    .front (front_q),
    .num   (hsi_num)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CTL_DEPTH; i++) begin
        ctl_q[i].valid <= 1'b0;
      end
    end else if (en) begin
      ctl_q[0] <= front_q.ctl;
      for (int i = 1; i < CTL_DEPTH; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // Both model paths land together; the model choice picks which one to divide.
  assign sel_num = ctl_q[5].use_hsi ? hsi_num : hsv_num;

  hsx_div u_div_r (
    .clk     (clk),
    .en      (en),
    .num     (sel_num.r),
    .use_hsi (ctl_q[5].use_hsi),
    .chan    (red_q)
  );

  hsx_div u_div_g (
    .clk     (clk),
    .en      (en),
    .num     (sel_num.g),
    .use_hsi (ctl_q[5].use_hsi),
    .chan    (green_q)
  );

  hsx_div u_div_b (
    .clk     (clk),
    .en      (en),
    .num     (sel_num.b),
    .use_hsi (ctl_q[5].use_hsi),
    .chan    (blue_q)
  );

  // Grey cases (HSI with no saturation or no hue, and the unused model code)
  // show the input level on every channel.
  assign color_valid   = ctl_q[CTL_DEPTH-1].valid;
  assign color.red     = ctl_q[CTL_DEPTH-1].grey ? ctl_q[CTL_DEPTH-1].lvl : red_q;
  assign color.green   = ctl_q[CTL_DEPTH-1].grey ? ctl_q[CTL_DEPTH-1].lvl : green_q;
  assign color.blue    = ctl_q[CTL_DEPTH-1].grey ? ctl_q[CTL_DEPTH-1].lvl : blue_q;
  assign color.opacity = ctl_q[CTL_DEPTH-1].alpha;

endmodule

`default_nettype wire

[hdl/hsx_checker.sv]
`default_nettype none

module hsx_checker (
  input logic            clk,
  input logic            rst,
  input logic            pixel_valid,
  input logic            pixel_ready,
  input logic            color_valid,
  input logic            color_ready,
  input hsx_pkg::color_t color
);

  // A waiting color stays offered.
  a_color_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |=> color_valid)
    else $error("color_valid dropped before its transfer");

  // A waiting color keeps its value.
  a_color_stable: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |=> $stable(color))
    else $error("color changed while stalled");

  // A stalled output stops the intake so no pixel is lost in flight.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |-> !pixel_ready)
    else $error("pixel accepted while the output is stalled");

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !color_valid)
    else $error("color_valid set right after reset");

endmodule

bind hsv_hsl_hsi_to_rgb hsx_checker u_hsx_checker (.*);

`default_nettype wire
